// File: src/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZ77 token decompressor: parse phases,
// command beat format passed from the parser to the copy engine.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int WINDOW_BITS_DEF      = 16;
    localparam int BYTES_PER_RESULT_DEF = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [7:0] C_ESC      = 8'h81;
    localparam logic [7:0] C_MSB      = 8'h80;
    localparam logic [7:0] C_LOW7     = 8'h7F;
    localparam logic [7:0] C_MAGIC_V1 = 8'h4D;  // 'M'
    localparam logic [7:0] C_MAGIC_V2 = 8'h6D;  // 'm'
    localparam logic [7:0] C_MAGIC_B1 = 8'h5A;  // 'Z'
    localparam logic [8:0] C_MIN_MATCH = 9'd3;

    typedef enum logic [3:0] {
        PH_MAGIC0 = 4'd0,
        PH_MAGIC1 = 4'd1,
        PH_LEN0   = 4'd2,
        PH_LEN1   = 4'd3,
        PH_LEN2   = 4'd4,
        PH_LEN3   = 4'd5,
        PH_TOKEN  = 4'd6,
        PH_ESC    = 4'd7,
        PH_MATCH1 = 4'd8,
        PH_MATCH2 = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        END_NONE = 2'd0,
        END_OK   = 2'd1,
        END_ERR  = 2'd2
    } t_end;

    typedef enum logic [1:0] {
        K_QUIET = 2'd0,
        K_LIT   = 2'd1,
        K_MATCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_RD   = 2'd1,
        B_WR   = 2'd2
    } t_bstate;

    // one command per accepted input beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  lit;
        logic [15:0] off;
        logic [8:0]  len;
        logic [31:0] exp_len;
        t_end        endc;
        logic        in_tok;
        logic        last;
        logic        last_ok;
    } t_cmd;

endpackage

// File: src/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Stream parser: tracks header and token phase and turns each input beat
// into one command for the copy engine.
// ----------------------------------------------------------------------------
module lzd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output lzd_pkg::t_cmd o_cmd
);
    import lzd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_v2, n_v2;
    logic [31:0] r_exp, n_exp;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_second, n_second;

    // decode the current beat
    always_comb begin
        n_phase  = r_phase;
        n_v2     = r_v2;
        n_exp    = r_exp;
        n_first  = r_first;
        n_second = r_second;
        o_cmd.kind = K_QUIET;
        o_cmd.lit  = i_byte;
        o_cmd.off  = 16'd0;
        o_cmd.len  = 9'd0;
        o_cmd.endc = END_NONE;
        case (r_phase)
            PH_MAGIC0: begin
                if (i_byte == C_MAGIC_V1) begin
                    n_v2 = 1'b0;
                    n_phase = PH_MAGIC1;
                end else if (i_byte == C_MAGIC_V2) begin
                    n_v2 = 1'b1;
                    n_phase = PH_MAGIC1;
                end else begin
                    o_cmd.endc = END_ERR;
                end
            end
            PH_MAGIC1: begin
                if (i_byte == C_MAGIC_B1) n_phase = PH_LEN0;
                else o_cmd.endc = END_ERR;
            end
            PH_LEN0: begin
                n_exp[7:0] = i_byte;
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_exp[15:8] = i_byte;
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_exp[23:16] = i_byte;
                n_phase = PH_LEN3;
            end
            PH_LEN3: begin
                n_exp[31:24] = i_byte;
                n_phase = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (i_byte == C_ESC) begin
                    n_phase = PH_ESC;
                end else if ((i_byte & C_MSB) != 8'd0) begin
                    n_first = i_byte;
                    n_phase = PH_MATCH1;
                end else begin
                    o_cmd.kind = K_LIT;
                end
            end
            PH_ESC: begin
                o_cmd.kind = K_LIT;
                n_phase = PH_TOKEN;
            end
            PH_MATCH1: begin
                n_second = i_byte;
                n_phase = PH_MATCH2;
            end
            PH_MATCH2: begin
                if (r_v2) begin
                    o_cmd.off = {r_first[6:0], r_second, i_byte[7]};
                    o_cmd.len = {2'b00, i_byte[6:0]} + C_MIN_MATCH;
                end else begin
                    o_cmd.off = {1'b0, r_first[6:0], r_second};
                    o_cmd.len = {1'b0, i_byte} + C_MIN_MATCH;
                end
                n_phase = PH_TOKEN;
                if (o_cmd.off == 16'd0) o_cmd.endc = END_OK;
                else o_cmd.kind = K_MATCH;
            end
            default: begin
                o_cmd.endc = END_ERR;
            end
        endcase
        o_cmd.exp_len = n_exp;
        o_cmd.in_tok  = (n_phase >= PH_TOKEN);
        o_cmd.last    = i_last;
        o_cmd.last_ok = (n_phase == PH_TOKEN);
    end

    // advance parse state; restart on the final beat of a stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC0;
            r_v2     <= 1'b0;
            r_exp    <= 32'd0;
            r_first  <= 8'd0;
            r_second <= 8'd0;
        end else if (i_take) begin
            if (i_last) begin
                r_phase  <= PH_MAGIC0;
                r_v2     <= 1'b0;
                r_exp    <= 32'd0;
                r_first  <= 8'd0;
                r_second <= 8'd0;
            end else begin
                r_phase  <= n_phase;
                r_v2     <= n_v2;
                r_exp    <= n_exp;
                r_first  <= n_first;
                r_second <= n_second;
            end
        end
    end

endmodule

// File: src/lzd_queue.sv
// ----------------------------------------------------------------------------
// lzd_queue
// Small command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lzd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output lzd_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import lzd_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // store pushed beats
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// File: src/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// Copy engine: writes literals and match copies into the history window,
// packs decoded bytes into result beats and decides stream end.
// ----------------------------------------------------------------------------
module lzd_back #(
    parameter int WINDOW_BITS      = lzd_pkg::WINDOW_BITS_DEF,
    parameter int BYTES_PER_RESULT = lzd_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lzd_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [63:0]   o_data_bytes,
    output logic [3:0]    o_byte_count,
    output logic          o_run_last,
    output logic          o_stream_done,
    output logic          o_status,
    output logic [31:0]   o_total_length
);
    import lzd_pkg::*;

    localparam int WIN_SIZE = 1 << WINDOW_BITS;

    logic [7:0] r_win [WIN_SIZE];

    t_bstate                r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [8:0]             r_i, n_i;
    logic [WINDOW_BITS-1:0] r_wp, n_wp;
    logic                   r_wrap, n_wrap;
    logic [31:0]            r_prod, n_prod;
    logic                   r_fin, n_fin;
    logic [63:0]            r_pack, n_pack;
    logic [3:0]             r_cnt, n_cnt;
    logic [7:0]             r_rdata;
    logic                   r_rvalid;

    logic                   r_ov;
    logic [63:0]            r_od;
    logic [3:0]             r_oc;
    logic                   r_orl, r_osd, r_ost;
    logic [31:0]            r_otl;

    logic                   can_emit, we, rd_en, em, em_rl, sdone;
    logic [7:0]             wdata, cbyte;
    logic [63:0]            em_data;
    logic [3:0]             em_cnt;
    logic [31:0]            em_total;
    t_end                   em_end, e;
    logic [WINDOW_BITS-1:0] raddr;

    // end code of a beat once its bytes are produced
    function automatic t_end end_of(input t_cmd c, input logic [31:0] prod);
        t_end r;
        r = END_NONE;
        if (c.endc != END_NONE) r = c.endc;
        else if (c.in_tok && prod >= c.exp_len) r = END_OK;
        else if (c.last) r = c.last_ok ? END_OK : END_ERR;
        return r;
    endfunction

    assign raddr = r_wp - r_cmd.off[WINDOW_BITS-1:0];
    assign rd_en = (r_state == B_RD);

    // sequence commands and build result beats
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_i     = r_i;
        n_wp    = r_wp;
        n_wrap  = r_wrap;
        n_prod  = r_prod;
        n_fin   = r_fin;
        n_pack  = r_pack;
        n_cnt   = r_cnt;
        can_emit = !r_ov || !i_stall;
        o_pop    = 1'b0;
        we       = 1'b0;
        wdata    = 8'd0;
        em       = 1'b0;
        em_rl    = 1'b1;
        em_data  = 64'd0;
        em_cnt   = 4'd0;
        em_total = r_prod;
        em_end   = END_NONE;
        e        = END_NONE;
        sdone    = 1'b0;
        cbyte    = r_rvalid ? r_rdata : 8'd0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty && can_emit) begin
                    o_pop = 1'b1;
                    if (!r_fin) begin
                        case (i_cmd.kind)
                            K_LIT: begin
                                we       = 1'b1;
                                wdata    = i_cmd.lit;
                                n_wp     = r_wp + 1'b1;
                                n_prod   = r_prod + 32'd1;
                                if (&r_wp) n_wrap = 1'b1;
                                e        = end_of(i_cmd, r_prod + 32'd1);
                                em       = 1'b1;
                                em_data  = {56'd0, i_cmd.lit};
                                em_cnt   = 4'd1;
                                em_total = r_prod + 32'd1;
                                em_end   = e;
                            end
                            K_MATCH: begin
                                n_cmd   = i_cmd;
                                n_i     = 9'd0;
                                n_state = B_RD;
                            end
                            default: begin
                                e = end_of(i_cmd, r_prod);
                                if (e != END_NONE) begin
                                    em     = 1'b1;
                                    em_end = e;
                                end
                            end
                        endcase
                        if (e != END_NONE) n_fin = 1'b1;
                    end
                    if (i_cmd.last && (r_fin || i_cmd.kind != K_MATCH)) begin
                        n_wp   = '0;
                        n_wrap = 1'b0;
                        n_prod = 32'd0;
                        n_fin  = 1'b0;
                    end
                end
            end
            B_RD: begin
                n_state = B_WR;
            end
            B_WR: begin
                if (can_emit) begin
                    we     = 1'b1;
                    wdata  = cbyte;
                    n_wp   = r_wp + 1'b1;
                    n_prod = r_prod + 32'd1;
                    if (&r_wp) n_wrap = 1'b1;
                    n_i    = r_i + 9'd1;
                    n_pack[{r_cnt[2:0], 3'b000} +: 8] = cbyte;
                    n_cnt  = r_cnt + 4'd1;
                    sdone  = ((r_i + 9'd1) == r_cmd.len) ||
                             ((r_prod + 32'd1) >= r_cmd.exp_len);
                    if (sdone || n_cnt == 4'(BYTES_PER_RESULT)) begin
                        em       = 1'b1;
                        em_data  = n_pack;
                        em_cnt   = n_cnt;
                        em_rl    = sdone;
                        em_total = r_prod + 32'd1;
                        em_end   = sdone ? end_of(r_cmd, r_prod + 32'd1) : END_NONE;
                        n_pack   = 64'd0;
                        n_cnt    = 4'd0;
                    end
                    if (sdone) begin
                        n_state = B_IDLE;
                        if (em_end != END_NONE) n_fin = 1'b1;
                        if (r_cmd.last) begin
                            n_wp   = '0;
                            n_wrap = 1'b0;
                            n_prod = 32'd0;
                            n_fin  = 1'b0;
                        end
                    end else begin
                        n_state = B_RD;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // history window: write one byte, read one byte for match copies
    always_ff @(posedge i_clk) begin
        if (we) r_win[r_wp] <= wdata;
        if (rd_en) begin
            r_rdata  <= r_win[raddr];
            r_rvalid <= r_wrap || (raddr < r_wp);
        end
    end

    // hold engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_i     <= 9'd0;
            r_wp    <= '0;
            r_wrap  <= 1'b0;
            r_prod  <= 32'd0;
            r_fin   <= 1'b0;
            r_pack  <= 64'd0;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_wp    <= n_wp;
            r_wrap  <= n_wrap;
            r_prod  <= n_prod;
            r_fin   <= n_fin;
            r_pack  <= n_pack;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // output register: load a beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (em) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em) begin
            r_od  <= em_data;
            r_oc  <= em_cnt;
            r_orl <= em_rl;
            r_osd <= (em_end != END_NONE);
            r_ost <= (em_end == END_ERR);
            r_otl <= em_total;
        end
    end

    assign o_valid        = r_ov;
    assign o_data_bytes   = r_od;
    assign o_byte_count   = r_oc;
    assign o_run_last     = r_orl;
    assign o_stream_done  = r_osd;
    assign o_status       = r_ost;
    assign o_total_length = r_otl;

endmodule

// File: src/lz77_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz77_token_decompressor
// Streaming LZ77 token decoder with a 2**WINDOW_BITS byte history window (64K by default).
// ----------------------------------------------------------------------------
// Header bytes and literals are taken one per cycle while the output side
// keeps up; a match blocks the command queue while it copies, each copied
// byte taking one window read and one write (B_RD, then B_WR) over a
// single-port history memory. Packed result beats carry up to
// BYTES_PER_RESULT bytes. The window needs no clearing pass: a write fill
// mark makes unwritten entries read as zero.
module lz77_token_decompressor #(
    parameter int WINDOW_BITS      = lzd_pkg::WINDOW_BITS_DEF,
    parameter int BYTES_PER_RESULT = lzd_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_stream_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_data_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_stream_done,
    output logic        o_status,
    output logic [31:0] o_total_length
);
    import lzd_pkg::*;

    t_cmd f_cmd, q_cmd;
    logic take, pop, full, empty;

    assign o_in_stall = full;
    assign take       = i_in_valid && !full;

    lzd_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (i_stream_byte),
        .i_last (i_stream_last),
        .o_cmd  (f_cmd)
    );

    lzd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (take),
        .i_cmd  (f_cmd),
        .i_pop  (pop),
        .o_cmd  (q_cmd),
        .o_full (full),
        .o_empty(empty)
    );

    lzd_back #(
        .WINDOW_BITS     (WINDOW_BITS),
        .BYTES_PER_RESULT(BYTES_PER_RESULT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_data_bytes  (o_data_bytes),
        .o_byte_count  (o_byte_count),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done),
        .o_status      (o_status),
        .o_total_length(o_total_length)
    );

endmodule

// File: src/lzd_checker.sv
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks on result beats of the decompressor.
// ----------------------------------------------------------------------------
module lzd_checker #(
    parameter int BYTES_PER_RESULT = lzd_pkg::BYTES_PER_RESULT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_data_bytes,
    input logic [3:0]  o_byte_count,
    input logic        o_run_last,
    input logic        o_stream_done,
    input logic        o_status
);
    // stream end only on the closing beat of an input byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_done |-> o_run_last)
        else $error("stream_done without run_last");

    // error flag only with stream end
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_stream_done)
        else $error("status without stream_done");

    // an empty beat only closes a stream, and carries zero data
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count == 4'd0 |-> o_stream_done && o_data_bytes == 64'd0)
        else $error("empty beat outside stream end");

    // never more bytes than a beat holds
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count <= 4'(BYTES_PER_RESULT))
        else $error("byte_count too large");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_bytes))
        else $error("stalled beat changed");

endmodule

bind lz77_token_decompressor lzd_checker #(
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
) u_lzd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_data_bytes (o_data_bytes),
    .o_byte_count (o_byte_count),
    .o_run_last   (o_run_last),
    .o_stream_done(o_stream_done),
    .o_status     (o_status)
);
